>>> rtl/verb_noun_keypad_interpreter_core_macros.svh
// Assertion macros used by the checker of the keypad interpreter.
`ifndef VERB_NOUN_KEYPAD_INTERPRETER_CORE_MACROS_SVH
`define VERB_NOUN_KEYPAD_INTERPRETER_CORE_MACROS_SVH

// same-cycle implication
`define VNK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VNK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/vnk_pkg.sv
package vnk_pkg;

	localparam int STORE_WORDS = 128;
	localparam int ADDR_W = $clog2(STORE_WORDS);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_VERB    = 3'd1,
		MODE_NOUN    = 3'd2,
		MODE_DATA    = 3'd3,
		MODE_MONITOR = 3'd4,
		MODE_ERROR   = 3'd5
	} mode_t;

	localparam logic [7:0] KEY_V    = 8'h76;
	localparam logic [7:0] KEY_N    = 8'h6E;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_HASH = 8'h23;
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_NINE = 8'h39;

	localparam logic [6:0] VERB_MON_FIRST  = 7'd11;
	localparam logic [6:0] VERB_MON_LAST   = 7'd13;
	localparam logic [6:0] VERB_LOAD_FIRST = 7'd21;
	localparam logic [6:0] VERB_LOAD_LAST  = 7'd23;
	localparam logic [6:0] LOAD_BASE       = 7'd20;
	localparam logic [6:0] VERB_RESET      = 7'd36;
	localparam logic [6:0] VERB_PROGRAM    = 7'd37;
	localparam logic [6:0] NOUN_PROGRAM    = 7'd50;

	localparam int OPND_W = 34;
	localparam int EDIT_W = 30;
	localparam logic [OPND_W-1:0] WORD_MOD = 34'd1000000000;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  verb;
		logic [6:0]  noun;
		logic [1:0]  index;
		logic [31:0] edit;
		logic        prog_start;
		logic [6:0]  prog_num;
		logic        rst_req;
	} result_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} store_req_t;

	typedef struct packed {
		logic              done;
		logic [EDIT_W-1:0] rem;
	} mod_status_t;

	// (value*10 + digit) mod 100 for value below 100
	function automatic logic [6:0] next_two_digit(input logic [6:0] value,
		input logic [3:0] digit);
		logic [9:0]  v;
		logic [15:0] p;
		logic [3:0]  q;
		logic [9:0]  r;
		v = {value, 3'b000} + {2'b00, value, 1'b0} + 10'(digit);
		p = 16'(v) * 16'd41;
		q = p[15:12];
		r = v - 10'(q) * 10'd100;
		return r[6:0];
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [6:0] noun,
		input logic [1:0] offset);
		logic [ADDR_W:0] s;
		s = (ADDR_W+1)'(noun) + (ADDR_W+1)'(offset);
		return s[ADDR_W-1:0];
	endfunction

endpackage

>>> rtl/vnk_word_store.sv
module vnk_word_store (
	input  logic               clk,
	input  vnk_pkg::store_req_t req,
	output logic [31:0]        rdata
);
	import vnk_pkg::*;

	logic [31:0] mem [STORE_WORDS];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/vnk_mod_unit.sv
module vnk_mod_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [vnk_pkg::OPND_W-1:0] operand,
	output vnk_pkg::mod_status_t      status
);
	import vnk_pkg::*;

	logic              busy_q;
	logic [1:0]        step_q;
	logic [OPND_W-1:0] rem_q;
	logic [OPND_W-1:0] k;
	logic [OPND_W-1:0] sub;
	logic              take;

	assign k    = WORD_MOD << step_q;
	assign sub  = rem_q - k;
	assign take = rem_q >= k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 2'd3;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
		end else if (busy_q && take) begin
			rem_q <= sub;
		end
	end

	assign status.done = busy_q && (step_q == 2'd0);
	assign status.rem  = take ? sub[EDIT_W-1:0] : rem_q[EDIT_W-1:0];

endmodule

>>> rtl/vnk_out_fifo.sv
module vnk_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vnk_pkg::result_t din,
	output logic             full,
	output logic             valid,
	input  logic             ready,
	output vnk_pkg::result_t dout
);
	import vnk_pkg::*;

	result_t    ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop   = valid && ready;
	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

>>> rtl/verb_noun_keypad_interpreter_core.sv
// Verb/noun keypad interpreter: one ASCII key per input transaction, one status transaction
// out per key. Most keys are handled in ST_READY alone, so keys can stream back to back while
// the output queue is not full. A data digit waits in ST_MOD for the four-step
// remainder-of-1e9 reduction in the iterative unit. A verb 21-23 execute waits in ST_LOAD for
// three reads of the single-port word store. After reset and after verb 36 the store is swept
// to zero, one word a cycle, for all STORE_WORDS (128) words, with s_axis_tready low. A 2-entry
// output queue lets keys be taken while a result waits.
module verb_noun_keypad_interpreter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] key_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] mode, [9:3] verb_value, [16:10] noun_value, [18:17] data_index,
	// [50:19] edit_value, [57:51] program_number, [63:58] zero
	output logic [63:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // [0] program_start, [1] reset_request
);
	import vnk_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_READY = 4'b0010,
		ST_LOAD  = 4'b0100,
		ST_MOD   = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	mode_t             mode_q, mode_d;
	logic [6:0]        verb_q, verb_d;
	logic [6:0]        noun_q, noun_d;
	logic [1:0]        idx_q, idx_d;
	logic [31:0]       edit_q [3];
	logic [31:0]       edit_d [3];
	logic [6:0]        prog_q, prog_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [1:0]        ld_q, ld_d;

	logic              accept;
	logic [7:0]        key;
	logic              is_digit;
	logic [3:0]        digit;
	logic [31:0]       cur_edit;
	logic [OPND_W-1:0] mod_opnd;
	logic              mod_start;
	mod_status_t       mod_st;
	store_req_t        mem_req;
	logic [31:0]       mem_rdata;
	logic              push;
	result_t           res;
	result_t           out_res;
	logic              fifo_full;
	logic              start_pulse;
	logic              reset_pulse;

	assign key      = s_axis_tdata;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
	assign digit    = is_digit ? 4'(key - KEY_ZERO) : 4'd0;

	always_comb begin
		case (idx_q)
			2'd0:    cur_edit = edit_q[0];
			2'd1:    cur_edit = edit_q[1];
			2'd2:    cur_edit = edit_q[2];
			default: cur_edit = 32'd0;
		endcase
	end

	assign mod_opnd = {1'b0, cur_edit[EDIT_W-1:0], 3'b000}
		+ {3'b000, cur_edit[EDIT_W-1:0], 1'b0} + OPND_W'(digit);

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		verb_d      = verb_q;
		noun_d      = noun_q;
		idx_d       = idx_q;
		edit_d      = edit_q;
		prog_d      = prog_q;
		clr_d       = clr_q;
		ld_d        = ld_q;
		push        = 1'b0;
		start_pulse = 1'b0;
		reset_pulse = 1'b0;
		mod_start   = 1'b0;
		mem_req     = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_req.en = 1'b1;
				mem_req.we = 1'b1;
				mem_req.addr = clr_q;
				clr_d = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(STORE_WORDS - 1)) begin
					state_d = ST_READY;
				end
			end
			ST_READY: begin
				if (accept) begin
					push = 1'b1;
					case (mode_q)
						MODE_IDLE, MODE_MONITOR: begin
							if (key == KEY_V) begin
								mode_d = MODE_VERB;
								verb_d = 7'd0;
							end
						end
						MODE_VERB: begin
							if (key == KEY_N) begin
								mode_d = MODE_NOUN;
								noun_d = 7'd0;
							end else if (key == KEY_STAR) begin
								verb_d = 7'd0;
							end else if (is_digit) begin
								verb_d = next_two_digit(verb_q, digit);
							end
						end
						MODE_NOUN: begin
							if (is_digit) begin
								noun_d = next_two_digit(noun_q, digit);
							end else if (key == KEY_STAR) begin
								noun_d = 7'd0;
							end else if (key == KEY_HASH) begin
								if ((verb_q >= VERB_MON_FIRST) && (verb_q <= VERB_MON_LAST)) begin
									mode_d = MODE_MONITOR;
								end else if ((verb_q >= VERB_LOAD_FIRST)
									&& (verb_q <= VERB_LOAD_LAST)) begin
									mode_d = MODE_DATA;
									idx_d = 2'd0;
									mem_req.en = 1'b1;
									mem_req.addr = store_addr(noun_q, 2'd0);
									ld_d = 2'd0;
									state_d = ST_LOAD;
									push = 1'b0;
								end else if (verb_q == VERB_RESET) begin
									mode_d = MODE_IDLE;
									verb_d = 7'd0;
									noun_d = 7'd0;
									idx_d = 2'd0;
									prog_d = 7'd0;
									for (int i = 0; i < 3; i++) begin
										edit_d[i] = 32'd0;
									end
									reset_pulse = 1'b1;
									clr_d = '0;
									state_d = ST_CLEAR;
								end else if ((verb_q == VERB_PROGRAM) && (noun_q == NOUN_PROGRAM)) begin
									prog_d = noun_q;
									verb_d = 7'd0;
									noun_d = 7'd0;
									mode_d = MODE_IDLE;
									start_pulse = 1'b1;
								end else begin
									mode_d = MODE_ERROR;
								end
							end
						end
						MODE_DATA: begin
							if (idx_q != 2'd3) begin
								if (is_digit) begin
									mod_start = 1'b1;
									state_d = ST_MOD;
									push = 1'b0;
								end else if (key == KEY_HASH) begin
									mem_req.en = 1'b1;
									mem_req.we = 1'b1;
									mem_req.addr = store_addr(noun_q, idx_q);
									mem_req.wdata = cur_edit;
									idx_d = idx_q + 2'd1;
									if (7'(idx_q) + 7'd1 + LOAD_BASE >= verb_q) begin
										mode_d = MODE_IDLE;
										verb_d = 7'd0;
										noun_d = 7'd0;
										idx_d = 2'd0;
									end
								end
							end
						end
						MODE_ERROR: begin
							if (key == KEY_STAR) begin
								mode_d = MODE_IDLE;
							end
						end
						default: begin
							mode_d = mode_q;
						end
					endcase
				end
			end
			ST_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					if (ld_q == 2'(i)) begin
						edit_d[i] = mem_rdata;
					end
				end
				ld_d = ld_q + 2'd1;
				if (ld_q == 2'd2) begin
					push = 1'b1;
					state_d = ST_READY;
				end else begin
					mem_req.en = 1'b1;
					mem_req.addr = store_addr(noun_q, ld_q + 2'd1);
				end
			end
			ST_MOD: begin
				if (mod_st.done) begin
					for (int i = 0; i < 3; i++) begin
						if (idx_q == 2'(i)) begin
							edit_d[i] = 32'(mod_st.rem);
						end
					end
					push = 1'b1;
					state_d = ST_READY;
				end
			end
			default: begin
				state_d = ST_READY;
			end
		endcase
	end

	always_comb begin
		res.mode       = mode_d;
		res.verb       = verb_d;
		res.noun       = noun_d;
		res.index      = idx_d;
		res.prog_start = start_pulse;
		res.prog_num   = prog_d;
		res.rst_req    = reset_pulse;
		case (idx_d)
			2'd0:    res.edit = edit_d[0];
			2'd1:    res.edit = edit_d[1];
			2'd2:    res.edit = edit_d[2];
			default: res.edit = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q  <= MODE_IDLE;
			verb_q  <= 7'd0;
			noun_q  <= 7'd0;
			idx_q   <= 2'd0;
			prog_q  <= 7'd0;
			clr_q   <= '0;
			ld_q    <= 2'd0;
			for (int i = 0; i < 3; i++) begin
				edit_q[i] <= 32'd0;
			end
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			verb_q  <= verb_d;
			noun_q  <= noun_d;
			idx_q   <= idx_d;
			prog_q  <= prog_d;
			clr_q   <= clr_d;
			ld_q    <= ld_d;
			edit_q  <= edit_d;
		end
	end

	vnk_word_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	vnk_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.operand (mod_opnd),
		.status  (mod_st)
	);

	vnk_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.full   (fifo_full),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.dout   (out_res)
	);

	assign s_axis_tready = (state_q == ST_READY) && !fifo_full;

	assign m_axis_tdata = {6'd0, out_res.prog_num, out_res.edit, out_res.index,
		out_res.noun, out_res.verb, out_res.mode};
	assign m_axis_tuser = {out_res.rst_req, out_res.prog_start};

endmodule

>>> rtl/vnk_checker.sv
`include "verb_noun_keypad_interpreter_core_macros.svh"

module vnk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import vnk_pkg::*;

	logic        stalled;
	logic        rst_seen;
	logic        start_seen;
	logic [65:0] out_word;
	logic [57:0] out_fields;
	logic [2:0]  out_mode;
	logic [16:0] out_cmd;
	logic [1:0]  out_index;
	logic [6:0]  out_prog;
	logic [5:0]  out_pad;

	assign stalled    = m_axis_tvalid && !m_axis_tready;
	assign rst_seen   = m_axis_tvalid && m_axis_tuser[1];
	assign start_seen = m_axis_tvalid && m_axis_tuser[0];
	assign out_word   = {m_axis_tuser, m_axis_tdata};
	assign out_fields = m_axis_tdata[57:0];
	assign out_mode   = m_axis_tdata[2:0];
	assign out_cmd    = m_axis_tdata[16:0];
	assign out_index  = m_axis_tdata[18:17];
	assign out_prog   = m_axis_tdata[57:51];
	assign out_pad    = m_axis_tdata[63:58];

	`VNK_ASSERT_NXT(a_out_hold, stalled, m_axis_tvalid && $stable(out_word), "result not held")

	`VNK_ASSERT_NOW(a_reset_clean, rst_seen, out_fields == '0 && !m_axis_tuser[0], "reset not clean")

	`VNK_ASSERT_NOW(a_prog_start, start_seen, out_prog == NOUN_PROGRAM && out_cmd == '0, "bad start")

	`VNK_ASSERT_NOW(a_mode_code, m_axis_tvalid, out_mode <= MODE_ERROR && out_pad == '0, "bad mode")

	`VNK_ASSERT_NOW(a_index_range, m_axis_tvalid, out_index != 2'd3, "bad index")

endmodule

bind verb_noun_keypad_interpreter_core vnk_checker u_vnk_checker (.*);

>>> bench/verb_noun_keypad_interpreter_core_tb.sv
`timescale 1ns / 1ps

module verb_noun_keypad_interpreter_core_tb;

	import vnk_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	verb_noun_keypad_interpreter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	typedef struct {
		logic [7:0] key;
		bit         typed;
		mode_t      mode;
		logic [6:0] verb;
		logic [6:0] noun;
		logic [6:0] prog;
		bit         start;
		bit         rst;
	} key_row_t;

	mode_t              kp_mode;
	logic [6:0]         kp_verb;
	logic [6:0]         kp_noun;
	logic [1:0]         kp_index;
	logic signed [31:0] kp_edit [3];
	logic signed [31:0] word_mem [STORE_WORDS];
	logic [6:0]         kp_prog;

	result_t status_q [$];
	key_row_t key_plan [27];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int keys_sent = 0;
	int keys_acted = 0;
	int results_seen = 0;
	int n_monitor = 0;
	int n_loads = 0;
	int n_words = 0;
	int n_resets = 0;
	int n_starts = 0;
	int n_rejected = 0;

	task automatic clear_state();
		kp_mode = MODE_IDLE;
		kp_verb = '0;
		kp_noun = '0;
		kp_index = '0;
		foreach (kp_edit[i]) kp_edit[i] = '0;
		foreach (word_mem[i]) word_mem[i] = '0;
		kp_prog = '0;
	endtask

	task automatic interpret_key(input logic [7:0] key, output result_t res, output bit acted);
		bit     is_digit;
		int     digit;
		longint wide;
		is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
		digit = int'(key) - int'(KEY_ZERO);
		res = '0;
		acted = 1'b0;
		case (kp_mode)
		MODE_IDLE, MODE_MONITOR: begin
			if (key == KEY_V) begin
				kp_mode = MODE_VERB;
				kp_verb = '0;
				acted = 1'b1;
			end
		end
		MODE_VERB: begin
			acted = 1'b1;
			if (key == KEY_N) begin
				kp_mode = MODE_NOUN;
				kp_noun = '0;
			end else if (key == KEY_STAR) begin
				kp_verb = '0;
			end else if (is_digit) begin
				kp_verb = 7'((int'(kp_verb) * 10 + digit) % 100);
			end else begin
				acted = 1'b0;
			end
		end
		MODE_NOUN: begin
			acted = 1'b1;
			if (is_digit) begin
				kp_noun = 7'((int'(kp_noun) * 10 + digit) % 100);
			end else if (key == KEY_STAR) begin
				kp_noun = '0;
			end else if (key == KEY_HASH) begin
				if (kp_verb >= VERB_MON_FIRST && kp_verb <= VERB_MON_LAST) begin
					kp_mode = MODE_MONITOR;
					n_monitor++;
				end else if (kp_verb >= VERB_LOAD_FIRST && kp_verb <= VERB_LOAD_LAST) begin
					kp_mode = MODE_DATA;
					kp_index = '0;
					for (int k = 0; k < 3; k++)
						kp_edit[k] = word_mem[(int'(kp_noun) + k) % STORE_WORDS];
					n_loads++;
				end else if (kp_verb == VERB_RESET) begin
					clear_state();
					res.rst_req = 1'b1;
					n_resets++;
				end else if (kp_verb == VERB_PROGRAM && kp_noun == NOUN_PROGRAM) begin
					kp_prog = kp_noun;
					kp_verb = '0;
					kp_noun = '0;
					kp_mode = MODE_IDLE;
					res.prog_start = 1'b1;
					n_starts++;
				end else begin
					kp_mode = MODE_ERROR;
					n_rejected++;
				end
			end else begin
				acted = 1'b0;
			end
		end
		MODE_DATA: begin
			if (kp_index < 3) begin
				if (is_digit) begin
					acted = 1'b1;
					wide = longint'(kp_edit[kp_index]) * 10 + digit;
					kp_edit[kp_index] = 32'(wide % 64'sd1000000000);
				end else if (key == KEY_HASH) begin
					acted = 1'b1;
					word_mem[(int'(kp_noun) + int'(kp_index)) % STORE_WORDS] = kp_edit[kp_index];
					kp_index++;
					n_words++;
					if (int'(kp_index) >= int'(kp_verb) - int'(LOAD_BASE)) begin
						kp_mode = MODE_IDLE;
						kp_verb = '0;
						kp_noun = '0;
						kp_index = '0;
					end
				end
			end
		end
		MODE_ERROR: begin
			if (key == KEY_STAR) begin
				kp_mode = MODE_IDLE;
				acted = 1'b1;
			end
		end
		default: ;
		endcase
		res.mode = kp_mode;
		res.verb = kp_verb;
		res.noun = kp_noun;
		res.index = kp_index;
		res.edit = (kp_index < 3) ? kp_edit[kp_index] : '0;
		res.prog_num = kp_prog;
	endtask

	task automatic send_key(input logic [7:0] key);
		result_t want;
		bit      acted;
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		do @(posedge clk); while (!s_axis_tready);
		interpret_key(key, want, acted);
		status_q.push_back(want);
		keys_sent++;
		if (acted)
			keys_acted++;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(99) < 6)
			send_key(8'($urandom_range(255)));
	endtask

	task automatic enter_number(input int value);
		if ($urandom_range(9) == 0)
			send_key(8'(KEY_ZERO + $urandom_range(9)));
		send_key(8'(KEY_ZERO + value / 10));
		send_key(8'(KEY_ZERO + value % 10));
	endtask

	task automatic random_command();
		int pick;
		int verb;
		int noun;
		int ndig;
		while (kp_mode != MODE_IDLE && kp_mode != MODE_MONITOR) begin
			case (kp_mode)
			MODE_ERROR: send_key(KEY_STAR);
			MODE_VERB:  send_key(KEY_N);
			default:    send_key(KEY_HASH);
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 20)
			verb = $urandom_range(13, 11);
		else if (pick < 62)
			verb = $urandom_range(23, 21);
		else if (pick < 65)
			verb = VERB_RESET;
		else if (pick < 78)
			verb = VERB_PROGRAM;
		else
			verb = $urandom_range(99);
		pick = $urandom_range(99);
		if (verb == VERB_PROGRAM)
			noun = (pick < 80) ? NOUN_PROGRAM : $urandom_range(99);
		else if (verb >= VERB_LOAD_FIRST && verb <= VERB_LOAD_LAST && pick < 70)
			noun = $urandom_range(7);
		else if (pick < 80)
			noun = $urandom_range(99, 95);
		else
			noun = $urandom_range(99);

		send_key(KEY_V);
		maybe_noise();
		if ($urandom_range(9) == 0) begin
			enter_number($urandom_range(99));
			send_key(KEY_STAR);
		end
		enter_number(verb);
		maybe_noise();
		send_key(KEY_N);
		if ($urandom_range(9) == 0) begin
			enter_number($urandom_range(99));
			send_key(KEY_STAR);
		end
		enter_number(noun);
		maybe_noise();
		send_key(KEY_HASH);
		while (kp_mode == MODE_DATA) begin
			ndig = ($urandom_range(7) == 0) ? $urandom_range(12, 10) : $urandom_range(6);
			repeat (ndig) begin
				send_key(8'(KEY_ZERO + $urandom_range(9)));
				maybe_noise();
			end
			send_key(KEY_HASH);
		end
	endtask

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch_status
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (status_q.size() == 0) begin
				report_mismatch("unexpected transaction", 0, m_axis_tdata);
			end else begin
				want = status_q.pop_front();
				if (m_axis_tdata[2:0] != want.mode)
					report_mismatch("mode", want.mode, m_axis_tdata[2:0]);
				if (m_axis_tdata[9:3] != want.verb)
					report_mismatch("verb_value", want.verb, m_axis_tdata[9:3]);
				if (m_axis_tdata[16:10] != want.noun)
					report_mismatch("noun_value", want.noun, m_axis_tdata[16:10]);
				if (m_axis_tdata[18:17] != want.index)
					report_mismatch("data_index", want.index, m_axis_tdata[18:17]);
				if (m_axis_tdata[50:19] != want.edit)
					report_mismatch("edit_value", $signed(want.edit),
						$signed(m_axis_tdata[50:19]));
				if (m_axis_tdata[57:51] != want.prog_num)
					report_mismatch("program_number", want.prog_num, m_axis_tdata[57:51]);
				if (m_axis_tdata[63:58] != '0)
					report_mismatch("tdata padding", 0, m_axis_tdata[63:58]);
				if (m_axis_tuser[0] != want.prog_start)
					report_mismatch("program_start", want.prog_start, m_axis_tuser[0]);
				if (m_axis_tuser[1] != want.rst_req)
					report_mismatch("reset_request", want.rst_req, m_axis_tuser[1]);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int      idle_set [4];
		int      stall_set [4];
		int      target;
		result_t want;
		idle_set = '{0, 76, 0, 30};
		stall_set = '{0, 0, 76, 30};
		key_plan = '{
			'{8'h00,                  1, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'hFF,                  1, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_V,                  1, MODE_VERB,  0,  0,  0, 0, 0},
			'{KEY_NINE,               0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_NINE,               0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_NINE,               1, MODE_VERB, 99,  0,  0, 0, 0},
			'{KEY_STAR,               1, MODE_VERB,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 3),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 7),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_N,                  0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 5),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 1),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_HASH,               1, MODE_ERROR, 37, 51, 0, 0, 0},
			'{KEY_V,                  1, MODE_ERROR, 37, 51, 0, 0, 0},
			'{KEY_STAR,               1, MODE_IDLE, 37, 51,  0, 0, 0},
			'{KEY_V,                  0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 3),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 7),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_N,                  0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 5),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_ZERO,               0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_HASH,               1, MODE_IDLE,  0,  0, 50, 1, 0},
			'{KEY_V,                  0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 3),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{8'(KEY_ZERO + 6),       0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_N,                  0, MODE_IDLE,  0,  0,  0, 0, 0},
			'{KEY_HASH,               1, MODE_IDLE,  0,  0,  0, 0, 1}
		};
		clear_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (key_plan[i]) begin
			send_key(key_plan[i].key);
			if (key_plan[i].typed) begin
				want = '0;
				want.mode = key_plan[i].mode;
				want.verb = key_plan[i].verb;
				want.noun = key_plan[i].noun;
				want.prog_num = key_plan[i].prog;
				want.prog_start = key_plan[i].start;
				want.rst_req = key_plan[i].rst;
				status_q[status_q.size() - 1] = want;
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			// hold the sender until the queue of pending status words has drained
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (status_q.size() != 0);
			idle_pct = idle_set[ph];
			stall_pct <= stall_set[ph];
			target = keys_acted + 400;
			while (keys_acted < target)
				random_command();
		end
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
		repeat (20) @(posedge clk);

		$display("Keys: %0d sent, %0d acted on; status transactions checked: %0d",
			keys_sent, keys_acted, results_seen);
		$display("Commands: %0d monitor, %0d loads, %0d words stored, %0d resets, %0d starts, %0d rejected",
			n_monitor, n_loads, n_words, n_resets, n_starts, n_rejected);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/vnk_pkg.sv
rtl/vnk_word_store.sv
rtl/vnk_mod_unit.sv
rtl/vnk_out_fifo.sv
rtl/verb_noun_keypad_interpreter_core.sv
rtl/vnk_checker.sv
bench/verb_noun_keypad_interpreter_core_tb.sv
